// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sda_pkg.sv
// ----------------------------------------------------------------------------
// sda_pkg
// Shared widths, character codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package sda_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int VAL_PORT_W  = 64;
  localparam int SCALE_W     = 7;
  localparam int CHAR_W      = 7;

  // Decimal digits needed for a VALUE_WIDTH-bit magnitude.
  localparam int NDIG      = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DIG_W     = $clog2(NDIG);
  localparam int FRAC_MAX  = 38;
  localparam int POS_MAX   = (NDIG - 1 > FRAC_MAX) ? NDIG - 1 : FRAC_MAX;
  localparam int POS_W     = $clog2(POS_MAX + 1);
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int FRAC_W    = 6;
  localparam int CNT_W     = 6;

  localparam logic signed [SCALE_W-1:0] SCALE_MAX = 7'sd39;
  localparam logic signed [SCALE_W-1:0] SCALE_MIN = -7'sd38;

  localparam logic [CNT_W-1:0] STAR_COUNT = 6'd7;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'd46;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_STAR  = 7'd42;

  typedef logic [2:0] sel_t;
  localparam sel_t SEL_MINUS = 3'd0;
  localparam sel_t SEL_DIGIT = 3'd1;
  localparam sel_t SEL_POINT = 3'd2;
  localparam sel_t SEL_ZERO  = 3'd3;
  localparam sel_t SEL_STAR  = 3'd4;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic scan_step;
    logic pos_fix;
    logic pos_dec;
    logic cnt_dec;
    sel_t sel;
  } sda_cmd_t;

  typedef struct packed {
    logic bad;
    logic neg;
    logic conv_done;
    logic scan_done;
    logic pos_zero;
    logic point_next;
    logic has_zeros;
    logic cnt_one;
  } sda_stat_t;

endpackage

// File: rtl/sda_if.sv
// ----------------------------------------------------------------------------
// sda_if
// Valid/ready channels: numeric request in, one character per transfer out.
// ----------------------------------------------------------------------------
interface sda_in_if;
  import sda_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [VAL_PORT_W-1:0] value;
  logic signed [SCALE_W-1:0]    scale;

  modport source (output valid, output value, output scale, input ready);
  modport sink   (input valid, input value, input scale, output ready);
endinterface

interface sda_out_if;
  import sda_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  logic              bad_scale;

  modport source (output valid, output char_code, output last, output bad_scale,
                  input ready);
  modport sink   (input valid, input char_code, input last, input bad_scale,
                  output ready);
endinterface

// File: rtl/sda_datapath.sv
// ----------------------------------------------------------------------------
// sda_datapath
// Magnitude/scale capture, shift-add-3 binary to BCD, digit scan and
// character selection.
// ----------------------------------------------------------------------------
module sda_datapath (
  input  logic                                 clk,
  input  logic signed [sda_pkg::VAL_PORT_W-1:0] value,
  input  logic signed [sda_pkg::SCALE_W-1:0]    scale,
  input  sda_pkg::sda_cmd_t                     cmd,
  output sda_pkg::sda_stat_t                    st,
  output logic [sda_pkg::CHAR_W-1:0]            char_code,
  output logic                                  bad_scale
);
  import sda_pkg::*;

  logic [VALUE_WIDTH-1:0] mag;
  logic [3:0]             bcd [NDIG];
  logic                   neg;
  logic                   bad;
  logic [FRAC_W-1:0]      frac;
  logic [CNT_W-1:0]       cnt;
  logic [BIT_CNT_W-1:0]   bitcnt;
  logic [POS_W-1:0]       pos;

  logic [VALUE_WIDTH-1:0] raw;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   bad_in;
  logic [SCALE_W-1:0]     scale_neg;
  logic [FRAC_W-1:0]      frac_in;
  logic [CNT_W-1:0]       zeros_in;
  logic [3:0]             adj [NDIG];
  logic [3:0]             cur_digit;
  logic [POS_W-1:0]       frac_ext;

  assign raw       = value[VALUE_WIDTH-1:0];
  assign neg_in    = raw[VALUE_WIDTH-1];
  assign mag_in    = neg_in ? (~raw + 1'b1) : raw;
  assign bad_in    = (scale > SCALE_MAX) || (scale < SCALE_MIN);
  assign scale_neg = -scale;
  assign frac_in   = scale[SCALE_W-1] ? scale_neg[FRAC_W-1:0] : '0;
  assign zeros_in  = scale[SCALE_W-1] ? '0 : scale[CNT_W-1:0];
  assign frac_ext  = POS_W'(frac);

  // Add-3 correction ahead of each shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // Positions above the BCD register are leading zeros.
  assign cur_digit = (pos < POS_W'(NDIG)) ? bcd[pos[DIG_W-1:0]] : 4'd0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag    <= mag_in;
      neg    <= neg_in;
      bad    <= bad_in;
      frac   <= frac_in;
      cnt    <= bad_in ? STAR_COUNT : zeros_in;
      bitcnt <= BIT_CNT_W'(VALUE_WIDTH);
      pos    <= POS_W'(NDIG - 1);
      for (int i = 0; i < NDIG; i++) begin
        bcd[i] <= 4'd0;
      end
    end else begin
      if (cmd.conv_step) begin
        mag    <= {mag[VALUE_WIDTH-2:0], 1'b0};
        bitcnt <= bitcnt - 1'b1;
        bcd[0] <= {adj[0][2:0], mag[VALUE_WIDTH-1]};
        for (int i = 1; i < NDIG; i++) begin
          bcd[i] <= {adj[i][2:0], adj[i-1][3]};
        end
      end
      if (cmd.scan_step || cmd.pos_dec) begin
        pos <= pos - 1'b1;
      end else if (cmd.pos_fix && (pos < frac_ext)) begin
        pos <= frac_ext;
      end
      if (cmd.cnt_dec) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign st.bad        = bad;
  assign st.neg        = neg;
  assign st.conv_done  = (bitcnt == BIT_CNT_W'(1));
  assign st.scan_done  = (pos == '0) || (cur_digit != 4'd0);
  assign st.pos_zero   = (pos == '0);
  assign st.point_next = (frac != '0) && (pos == frac_ext);
  assign st.has_zeros  = (cnt != '0);
  assign st.cnt_one    = (cnt == CNT_W'(1));

  always_comb begin
    case (cmd.sel)
      SEL_MINUS: char_code = CH_MINUS;
      SEL_DIGIT: char_code = CH_ZERO + CHAR_W'(cur_digit);
      SEL_POINT: char_code = CH_POINT;
      SEL_ZERO:  char_code = CH_ZERO;
      SEL_STAR:  char_code = CH_STAR;
      default:   char_code = CH_ZERO;
    endcase
  end

  assign bad_scale = (cmd.sel == SEL_STAR);

endmodule

// File: rtl/sda_ctrl.sv
// ----------------------------------------------------------------------------
// sda_ctrl
// Sequencer: capture, BCD conversion, leading-zero scan, character output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_last,
  input  sda_pkg::sda_stat_t  st,
  output sda_pkg::sda_cmd_t   cmd
);
  import sda_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_DIG  = 3'd4;
  localparam logic [2:0] ST_PT   = 3'd5;
  localparam logic [2:0] ST_ZERO = 3'd6;
  localparam logic [2:0] ST_STAR = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SIGN) || (state == ST_DIG) || (state == ST_PT) ||
                     (state == ST_ZERO) || (state == ST_STAR);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_ZERO;
    out_last   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (st.bad) begin
          state_next = ST_STAR;
        end else begin
          cmd.conv_step = 1'b1;
          if (st.conv_done) state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // walk down past leading zeros, then widen to the fraction length
        if (st.scan_done) begin
          cmd.pos_fix = 1'b1;
          state_next  = st.neg ? ST_SIGN : ST_DIG;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SIGN: begin
        cmd.sel = SEL_MINUS;
        if (out_ready) state_next = ST_DIG;
      end
      ST_DIG: begin
        cmd.sel  = SEL_DIGIT;
        out_last = st.pos_zero && !st.has_zeros;
        if (out_ready) begin
          if (st.point_next) begin
            cmd.pos_dec = 1'b1;
            state_next  = ST_PT;
          end else if (st.pos_zero) begin
            state_next = st.has_zeros ? ST_ZERO : ST_IDLE;
          end else begin
            cmd.pos_dec = 1'b1;
          end
        end
      end
      ST_PT: begin
        cmd.sel = SEL_POINT;
        if (out_ready) state_next = ST_DIG;
      end
      ST_ZERO, ST_STAR: begin
        cmd.sel  = (state == ST_STAR) ? SEL_STAR : SEL_ZERO;
        out_last = st.cnt_one;
        if (out_ready) begin
          cmd.cnt_dec = 1'b1;
          if (st.cnt_one) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SDA_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while emitting")
  `SDA_ASSERT_NOW(a_star_bad, state == ST_STAR, st.bad, "asterisks without bad scale")
  `SDA_ASSERT_NXT(a_last_idle, out_valid && out_ready && out_last, in_ready,
                  "not idle after final character")
  `SDA_ASSERT_NOW(a_run_nonzero, (state == ST_ZERO) || (state == ST_STAR), st.has_zeros,
                  "count exhausted while emitting")

endmodule

// File: rtl/scaled_decimal_to_ascii.sv
// ----------------------------------------------------------------------------
// scaled_decimal_to_ascii
// ASCII text of value * 10^scale, one character per output transfer.
// ----------------------------------------------------------------------------
// Sequence: the input request is taken, then one BCD shift step per bit of the
//   magnitude, then a leading-zero scan, then the characters.
// Throughput: one request at a time; one character per cycle while out_ch.ready is
//   high, 1 to 59 characters per request.
//   Bad scale: capture is followed straight by the '*' characters, with no conversion or scan.
// Reset: synchronous rst returns the sequencer to idle; no state between requests.
module scaled_decimal_to_ascii (
  input  logic      clk,
  input  logic      rst,
  sda_in_if.sink    in_ch,
  sda_out_if.source out_ch
);
  import sda_pkg::*;

  sda_cmd_t          cmd;
  sda_stat_t         st;
  logic [CHAR_W-1:0] char_code;
  logic              bad_scale;
  logic              in_ready;
  logic              out_valid;
  logic              out_last;

  sda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_last  (out_last),
    .st        (st),
    .cmd       (cmd)
  );

  sda_datapath u_dp (
    .clk       (clk),
    .value     (in_ch.value),
    .scale     (in_ch.scale),
    .cmd       (cmd),
    .st        (st),
    .char_code (char_code),
    .bad_scale (bad_scale)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = char_code;
  assign out_ch.last      = out_last;
  assign out_ch.bad_scale = bad_scale;

endmodule

// File: tb/scaled_decimal_to_ascii_test.sv
// ----------------------------------------------------------------------------
// scaled_decimal_to_ascii_test
// Self-checking bench for the scaled decimal to ASCII formatter. Requests of
// mantissa and scale go in; the character stream that comes back is compared
// one character at a time with the text of the directed row or the predictor. It runs a
// directed table first: zero, the value extremes, the scale limits and
// out-of-range scales. Random requests follow under three idle profiles.
// ----------------------------------------------------------------------------
module scaled_decimal_to_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sda_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RAND_PER_PASS = 60;

  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              bad_scale;
  } char_exp_t;

  typedef struct {
    logic [VAL_PORT_W-1:0] value;
    logic [SCALE_W-1:0]    scale;
    string                 text;   // empty: use the predictor
    bit                    bad;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  sda_in_if  in_ch();
  sda_out_if out_ch();

  scaled_decimal_to_ascii dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  char_exp_t pending_chars[$];
  dir_row_t  dir_rows[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int n_requests   = 0;
  int n_bad_reqs   = 0;
  int n_chars      = 0;
  int n_errors     = 0;
  int stall_cnt    = 0;

  // Text of value * 10^scale; flags an out-of-range scale.
  function automatic string scaled_text(input logic [VAL_PORT_W-1:0] v,
                                        input logic signed [SCALE_W-1:0] sc,
                                        output bit bad);
    logic [63:0] mask;
    logic [63:0] raw;
    logic [63:0] mag;
    bit          neg;
    int          s;
    string       txt;
    mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
    raw  = v & mask;
    neg  = raw[VALUE_WIDTH-1];
    // most negative value comes out as 2^(w-1), unsigned
    mag  = neg ? ((~raw + 64'd1) & mask) : raw;
    s    = sc;
    txt  = "";
    bad  = (s > int'(SCALE_MAX)) || (s < int'(SCALE_MIN));
    if (bad) begin
      for (int i = 0; i < int'(STAR_COUNT); i++) txt = $sformatf("%c%s", CH_STAR, txt);
      return txt;
    end
    while (s > 0) begin
      txt = $sformatf("%s%c", txt, CH_ZERO);
      s--;
    end
    // at least one integer digit, point before the last -scale digits
    while (mag != 64'd0 || s <= 0) begin
      txt = $sformatf("%c%s", CH_ZERO + CHAR_W'(mag % 64'd10), txt);
      s++;
      if (s == 0) txt = $sformatf("%c%s", CH_POINT, txt);
      mag = mag / 64'd10;
    end
    if (neg) txt = $sformatf("%c%s", CH_MINUS, txt);
    return txt;
  endfunction

  function automatic void queue_text(input string txt, input bit bad);
    char_exp_t c;
    for (int i = 0; i < txt.len(); i++) begin
      c.char_code = CHAR_W'(txt[i]);
      c.last      = (i == txt.len() - 1);
      c.bad_scale = bad;
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [VAL_PORT_W-1:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return v;
      1: return 64'($signed(32'($urandom_range(2000)) - 32'sd1000));
      2: return 64'($signed(v[31:0]));
      default: return $signed(v) >>> $urandom_range(63);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] random_scale();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return SCALE_W'($urandom_range(63, 40));
    if (r < 10) return SCALE_W'(-int'($urandom_range(64, 39)));
    if (r < 40) return SCALE_W'(int'($urandom_range(8)) - 4);
    return SCALE_W'(int'($urandom_range(77)) - 38);
  endfunction

  task automatic send_request(input logic [VAL_PORT_W-1:0] v,
                              input logic [SCALE_W-1:0] sc);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.scale <= sc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic run_request(input logic [VAL_PORT_W-1:0] v,
                             input logic [SCALE_W-1:0] sc,
                             input string typed_text, input bit typed_bad);
    string txt;
    bit    bad;
    send_request(v, sc);
    txt = scaled_text(v, sc, bad);
    if (typed_text.len() != 0) begin
      txt = typed_text;
      bad = typed_bad;
    end
    queue_text(txt, bad);
    n_requests++;
    if (bad) n_bad_reqs++;
  endtask

  // hold off new requests until the whole text stream is back
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic [VAL_PORT_W-1:0] v,
                                  input logic [SCALE_W-1:0] sc,
                                  input string txt, input bit bad);
    dir_row_t r;
    r.value = v;
    r.scale = sc;
    r.text  = txt;
    r.bad   = bad;
    dir_rows.push_back(r);
  endfunction

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    char_exp_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_chars++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character 0x%0h with no request pending", out_ch.char_code);
        n_errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.char_code !== want.char_code) begin
          $error("char_code: expected 0x%0h, got 0x%0h", want.char_code, out_ch.char_code);
          n_errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          n_errors++;
        end
        if (out_ch.bad_scale !== want.bad_scale) begin
          $error("bad_scale: expected %0b, got %0b", want.bad_scale, out_ch.bad_scale);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("scaled_decimal_to_ascii_test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.scale  <= '0;

    add_row(64'd0, 7'sd0, "0", 1'b0);
    add_row(64'd0, 7'sd3, "0000", 1'b0);
    add_row(64'd0, -7'sd3, "0.000", 1'b0);
    add_row(64'd1, 7'sd0, "1", 1'b0);
    add_row(-64'sd1, 7'sd0, "-1", 1'b0);
    add_row(-64'sd1, -7'sd1, "-0.1", 1'b0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 7'sd0, "9223372036854775807", 1'b0);
    add_row(64'h8000_0000_0000_0000, 7'sd0, "-9223372036854775808", 1'b0);
    add_row(64'd12345, -7'sd2, "123.45", 1'b0);
    add_row(64'd12345, -7'sd5, "0.12345", 1'b0);
    add_row(-64'sd12345, -7'sd7, "-0.0012345", 1'b0);
    add_row(64'd42, 7'sd2, "4200", 1'b0);
    add_row(64'd5, 7'sd40, "*******", 1'b1);
    add_row(64'd5, -7'sd39, "*******", 1'b1);
    add_row(64'h8000_0000_0000_0000, 7'sd63, "*******", 1'b1);
    add_row(64'd0, 7'h40, "*******", 1'b1);          // scale -64
    // longest text: most negative value with the largest scale
    add_row(64'h8000_0000_0000_0000, 7'sd39, "", 1'b0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, -7'sd38, "", 1'b0);
    add_row(-64'sd5, -7'sd38, "", 1'b0);
    add_row(64'd0, 7'sd39, "", 1'b0);
    add_row(64'd7, 7'sd39, "", 1'b0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 7'sd1, "", 1'b0);
    add_row(64'h5555_5555_5555_5555, -7'sd19, "", 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 31;
    snk_idle_pct = 52;
    foreach (dir_rows[i])
      run_request(dir_rows[i].value, dir_rows[i].scale, dir_rows[i].text, dir_rows[i].bad);
    drain_outputs();

    for (int i = 0; i < RAND_PER_PASS; i++) run_request(random_value(), random_scale(), "", 1'b0);
    drain_outputs();

    src_idle_pct = 52;
    snk_idle_pct = 31;
    for (int i = 0; i < RAND_PER_PASS; i++) run_request(random_value(), random_scale(), "", 1'b0);
    drain_outputs();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int i = 0; i < RAND_PER_PASS; i++) run_request(random_value(), random_scale(), "", 1'b0);
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d with out-of-range scale), %0d characters checked",
             n_requests, n_bad_reqs, n_chars);
    $display("Idle mixes: sender 31%%/receiver 52%%, swapped, then none; %0d mismatches",
             n_errors);
    if (n_errors == 0 && pending_chars.size() == 0) begin
      $display("scaled_decimal_to_ascii_test passed");
    end else begin
      $display("scaled_decimal_to_ascii_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/sda_pkg.sv
rtl/sda_if.sv
rtl/sda_datapath.sv
rtl/sda_ctrl.sv
rtl/scaled_decimal_to_ascii.sv
tb/scaled_decimal_to_ascii_test.sv
